// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with reset gating.
`define RBST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form of the above.
`define RBST_ASSERT_IMP(lbl, ante, cons, msg) \
  `RBST_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== rtl/rbst_pkg.sv =====
// Shared types and constants for the ray box slab test.
package rbst_pkg;

  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned DIFF_W   = 33;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5,
    REG_T_START  = 3'd6,
    REG_T_END    = 3'd7
  } rbst_reg_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][DIFF_W-1:0] dlo;
    logic [NUM_AXES-1:0][DIFF_W-1:0] dhi;
    logic [NUM_AXES-1:0]             zdir;
    logic                            zmiss;
  } rbst_word_t;

  localparam int unsigned WORD_W = $bits(rbst_word_t);

endpackage

// ===== rtl/ray_box_slab_test.sv =====
// Top level of the ray versus axis-aligned box slab test.
// Load the ray (origin, direction, t_start, t_end) through the cfg port while
// idle; then stream one box per word on the input channel, one box per cycle
// sustained while the output does not stall. Each box passes a 4-entry queue
// and then a divider pipeline of 33 stages (an input stage, then one quotient
// bit per stage, six dividers working side by side), an ordering stage and the
// result register. The input stalls only when the queue is full.
module ray_box_slab_test import rbst_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_box_min_x,
  input  logic [31:0] in_box_max_x,
  input  logic [31:0] in_box_min_y,
  input  logic [31:0] in_box_max_y,
  input  logic [31:0] in_box_min_z,
  input  logic [31:0] in_box_max_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [31:0] out_t_enter,
  output logic [31:0] out_t_exit
);

  logic [NUM_AXES-1:0][31:0] org_r, dir_r;
  logic [31:0]               t_start_r, t_end_r;
  rbst_word_t                f_word, q_word;
  logic                      q_full, q_nempty, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r     <= '0;
      dir_r     <= {32'h0000_0000, 32'h0000_0000, 32'h0001_0000};
      t_start_r <= '0;
      t_end_r   <= 32'h7FFF_FFFF;
    end else if (cfg_valid) begin
      unique case (rbst_reg_t'(cfg_index))
        REG_ORIGIN_X: org_r[0]  <= cfg_data;
        REG_ORIGIN_Y: org_r[1]  <= cfg_data;
        REG_ORIGIN_Z: org_r[2]  <= cfg_data;
        REG_DIR_X:    dir_r[0]  <= cfg_data;
        REG_DIR_Y:    dir_r[1]  <= cfg_data;
        REG_DIR_Z:    dir_r[2]  <= cfg_data;
        REG_T_START:  t_start_r <= cfg_data;
        REG_T_END:    t_end_r   <= cfg_data;
        default:      ;
      endcase
    end
  end

  rbst_front u_front (
    .org  (org_r),
    .dir  (dir_r),
    .bmin ({in_box_min_z, in_box_min_y, in_box_min_x}),
    .bmax ({in_box_max_z, in_box_max_y, in_box_max_x}),
    .word (f_word)
  );

  assign in_stall = q_full;

  rbst_fifo #(.W(WORD_W), .DEPTH(4)) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_valid && !q_full),
    .wdata  (f_word),
    .full   (q_full),
    .pop    (q_pop),
    .nempty (q_nempty),
    .rdata  (q_word)
  );

  rbst_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .dir         (dir_r),
    .t_start     (t_start_r),
    .t_end       (t_end_r),
    .q_nempty    (q_nempty),
    .q_word      (q_word),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_hit     (out_hit),
    .out_t_enter (out_t_enter),
    .out_t_exit  (out_t_exit)
  );

endmodule

// ===== rtl/rbst_front.sv =====
// Front end: offsets of box bounds from the origin and zero-direction checks.
module rbst_front import rbst_pkg::*; (
  input  logic [NUM_AXES-1:0][31:0] org,
  input  logic [NUM_AXES-1:0][31:0] dir,
  input  logic [NUM_AXES-1:0][31:0] bmin,
  input  logic [NUM_AXES-1:0][31:0] bmax,
  output rbst_word_t                word
);

  logic [NUM_AXES-1:0] zfail;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      word.dlo[a]  = DIFF_W'(signed'(bmin[a])) - DIFF_W'(signed'(org[a]));
      word.dhi[a]  = DIFF_W'(signed'(bmax[a])) - DIFF_W'(signed'(org[a]));
      word.zdir[a] = (dir[a] == 32'd0);
      zfail[a]     = word.zdir[a] &&
                     (($signed(org[a]) < $signed(bmin[a])) ||
                      ($signed(org[a]) > $signed(bmax[a])));
    end
    word.zmiss = |zfail;
  end

endmodule

// ===== rtl/rbst_fifo.sv =====
// Small register queue between front and back.
module rbst_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         nempty,
  output logic [W-1:0] rdata
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full   = (cnt_r == CW'(DEPTH));
  assign nempty = (cnt_r != '0);
  assign rdata  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== rtl/rbst_div.sv =====
// Pipelined saturating signed divider: an input stage, then one quotient bit per stage.
module rbst_div import rbst_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              en,
  input  logic [DIFF_W-1:0] diff,
  input  logic [31:0]       den,
  output logic [31:0]       quo
);

  localparam int unsigned NW = DIFF_W + FRAC_BITS;
  localparam int unsigned NS = 32;

  logic [DIFF_W-1:0] diff_mag;
  logic [NW-1:0]     num_mag;
  logic [31:0]       den_mag;

  logic [31:0] rem_r  [NS+1];
  logic [31:0] low_r  [NS+1];
  logic [31:0] q_r    [NS+1];
  logic [31:0] dmag_r [NS+1];
  logic        neg_r  [NS+1];
  logic        ovf_r  [NS+1];

  always_comb begin
    diff_mag = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
    num_mag  = {diff_mag, {FRAC_BITS{1'b0}}};
    den_mag  = den[31] ? (~den + 1'b1) : den;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= 32'(num_mag[NW-1:32]);
      low_r[0]  <= num_mag[31:0];
      q_r[0]    <= '0;
      dmag_r[0] <= den_mag;
      neg_r[0]  <= diff[DIFF_W-1] ^ den[31];
      ovf_r[0]  <= (32'(num_mag[NW-1:32]) >= den_mag);
    end
  end

  for (genvar i = 1; i <= NS; i++) begin : g_stage
    logic [32:0] trial;
    logic        ge;
    always_comb begin
      trial = {rem_r[i-1], low_r[i-1][31]};
      ge    = (trial >= {1'b0, dmag_r[i-1]});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? 32'(trial - {1'b0, dmag_r[i-1]}) : trial[31:0];
        low_r[i]  <= {low_r[i-1][30:0], 1'b0};
        q_r[i]    <= {q_r[i-1][30:0], ge};
        dmag_r[i] <= dmag_r[i-1];
        neg_r[i]  <= neg_r[i-1];
        ovf_r[i]  <= ovf_r[i-1];
      end
    end
  end

  always_comb begin
    if (neg_r[NS]) begin
      if (ovf_r[NS] || (q_r[NS] > 32'h8000_0000)) quo = 32'h8000_0000;
      else quo = ~q_r[NS] + 1'b1;
    end else begin
      if (ovf_r[NS] || q_r[NS][31]) quo = 32'h7FFF_FFFF;
      else quo = q_r[NS];
    end
  end

endmodule

// ===== rtl/rbst_back.sv =====
// Back end: slab divisions, ordering, interval narrowing and result register.
module rbst_back import rbst_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [NUM_AXES-1:0][31:0] dir,
  input  logic [31:0]               t_start,
  input  logic [31:0]               t_end,
  input  logic                      q_nempty,
  input  rbst_word_t                q_word,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_hit,
  output logic [31:0]               out_t_enter,
  output logic [31:0]               out_t_exit
);

  localparam int unsigned DL = 33;

  logic                en;
  logic [NUM_AXES-1:0][31:0] qlo, qhi;

  logic                vld_r   [DL];
  logic [NUM_AXES-1:0] zdir_r  [DL];
  logic                zmiss_r [DL];

  logic                      ord_vld_r;
  logic [NUM_AXES-1:0]       ord_zdir_r;
  logic                      ord_zmiss_r;
  logic [NUM_AXES-1:0][31:0] ord_a_r, ord_b_r;

  logic        ovld_r, ohit_r;
  logic [31:0] olo_r, ohi_r;
  logic [31:0] lo, hi;

  assign en    = !ovld_r || !out_stall;
  assign q_pop = en && q_nempty;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
      .clk(clk), .en(en), .diff(q_word.dlo[a]), .den(dir[a]), .quo(qlo[a])
    );
    rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
      .clk(clk), .en(en), .diff(q_word.dhi[a]), .den(dir[a]), .quo(qhi[a])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DL; s++) vld_r[s] <= 1'b0;
      ord_vld_r <= 1'b0;
      ovld_r    <= 1'b0;
    end else if (en) begin
      vld_r[0] <= q_nempty;
      for (int s = 1; s < DL; s++) vld_r[s] <= vld_r[s-1];
      ord_vld_r <= vld_r[DL-1];
      ovld_r    <= ord_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zdir_r[0]  <= q_word.zdir;
      zmiss_r[0] <= q_word.zmiss;
      for (int s = 1; s < DL; s++) begin
        zdir_r[s]  <= zdir_r[s-1];
        zmiss_r[s] <= zmiss_r[s-1];
      end
      ord_zdir_r  <= zdir_r[DL-1];
      ord_zmiss_r <= zmiss_r[DL-1];
      for (int a = 0; a < NUM_AXES; a++) begin
        if ($signed(qlo[a]) < $signed(qhi[a])) begin
          ord_a_r[a] <= qlo[a];
          ord_b_r[a] <= qhi[a];
        end else begin
          ord_a_r[a] <= qhi[a];
          ord_b_r[a] <= qlo[a];
        end
      end
    end
  end

  always_comb begin
    lo = t_start;
    hi = t_end;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (!ord_zdir_r[a]) begin
        if ($signed(ord_a_r[a]) > $signed(lo)) lo = ord_a_r[a];
        if ($signed(ord_b_r[a]) < $signed(hi)) hi = ord_b_r[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ohit_r <= !ord_zmiss_r && ($signed(hi) > $signed(lo));
      if (!ord_zmiss_r && ($signed(hi) > $signed(lo))) begin
        olo_r <= lo;
        ohi_r <= hi;
      end else begin
        olo_r <= '0;
        ohi_r <= '0;
      end
    end
  end

  assign out_valid   = ovld_r;
  assign out_hit     = ohit_r;
  assign out_t_enter = olo_r;
  assign out_t_exit  = ohi_r;

endmodule

// ===== rtl/rbst_chk.sv =====
// Port-level checker for the ray box slab test, bound to the top level.
`include "assert_macros.svh"

module rbst_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_hit,
  input logic [31:0] out_t_enter,
  input logic [31:0] out_t_exit
);

  `RBST_ASSERT_IMP(a_out_hold, out_valid && out_stall, ##1 out_valid, "result word dropped")
  `RBST_ASSERT_IMP(a_miss_zero, out_valid && !out_hit, (out_t_enter == 32'd0) && (out_t_exit == 32'd0), "miss with nonzero interval")
  `RBST_ASSERT_IMP(a_hit_order, out_valid && out_hit, $signed(out_t_exit) > $signed(out_t_enter), "hit with empty interval")

endmodule

bind ray_box_slab_test rbst_chk u_rbst_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_hit     (out_hit),
  .out_t_enter (out_t_enter),
  .out_t_exit  (out_t_exit)
);

// ===== tb/tb_ray_box_slab_test.sv =====
// Self-checking testbench for the ray versus axis-aligned box slab test.
module tb_ray_box_slab_test;
  import rbst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int LATENCY = 40;
  localparam int WATCHDOG = 20000;
  localparam longint S32MAX = 64'sd2147483647;
  localparam longint S32MIN = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] min_x, max_x, min_y, max_y, min_z, max_z;
  } box_t;
  typedef struct packed {
    logic        hit;
    logic [31:0] t_enter, t_exit;
  } span_t;

  logic clk = 0, rst_n = 0;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  box_t in_box = '0;
  logic out_valid, out_stall = 0, out_hit;
  logic [31:0] out_t_enter, out_t_exit;

  ray_box_slab_test u_top (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall,
    .in_box_min_x(in_box.min_x), .in_box_max_x(in_box.max_x),
    .in_box_min_y(in_box.min_y), .in_box_max_y(in_box.max_y),
    .in_box_min_z(in_box.min_z), .in_box_max_z(in_box.max_z),
    .out_valid, .out_stall, .out_hit, .out_t_enter, .out_t_exit
  );

  initial forever #4 clk = ~clk;

  longint ray_reg [8];
  box_t box_q [$];
  span_t span_q [$];
  int errors = 0, n_boxes = 0, n_hits = 0, n_spans = 0, idle_cycles = 0;
  bit busy = 0;
  int busy_pct = 28;
  int hold_off = 0;

  function automatic longint sx(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint slab_t(longint bound, longint org, longint d);
    longint q;
    q = ((bound - org) * (longint'(1) << FRAC)) / d;
    if (q > S32MAX) q = S32MAX;
    if (q < S32MIN) q = S32MIN;
    return q;
  endfunction

  function automatic span_t clip_span(box_t b);
    longint lo, hi, bmin, bmax, org, d, t0, t1;
    logic [31:0] bounds [6];
    span_t s;
    bit hit;
    lo = ray_reg[REG_T_START];
    hi = ray_reg[REG_T_END];
    hit = 1;
    bounds = '{b.min_x, b.max_x, b.min_y, b.max_y, b.min_z, b.max_z};
    for (int a = 0; a < 3; a++) begin
      bmin = sx(bounds[2*a]);
      bmax = sx(bounds[2*a+1]);
      org = ray_reg[a];
      d = ray_reg[3+a];
      if (d == 0) begin
        if (org < bmin || org > bmax) begin
          hit = 0;
          break;
        end
      end else begin
        t0 = slab_t(bmin, org, d);
        t1 = slab_t(bmax, org, d);
        if (t0 < t1) begin
          if (t0 > lo) lo = t0;
          if (t1 < hi) hi = t1;
        end else begin
          if (t1 > lo) lo = t1;
          if (t0 < hi) hi = t0;
        end
      end
      if (hi <= lo) begin
        hit = 0;
        break;
      end
    end
    if (!hit) begin
      lo = 0;
      hi = 0;
    end
    s.hit = hit;
    s.t_enter = lo[31:0];
    s.t_exit = hi[31:0];
    return s;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        span_q.push_back(clip_span(in_box));
        n_boxes++;
      end
      if (!(in_valid && in_stall)) begin
        if (box_q.size() > 0 && ($urandom_range(99) >= busy_pct)) begin
          in_valid <= 1;
          in_box <= box_q.pop_front();
        end else begin
          in_valid <= 0;
          in_box <= {6{$urandom()}};
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_spans++;
        if (span_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: hit=%0b", out_hit);
        end else begin
          span_t e;
          e = span_q.pop_front();
          if (out_hit !== e.hit || out_t_enter !== e.t_enter || out_t_exit !== e.t_exit) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp hit=%0b %h %h got hit=%0b %h %h",
                       e.hit, e.t_enter, e.t_exit, out_hit, out_t_enter, out_t_exit);
          end else if (e.hit) n_hits++;
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall <= 1;
      end else out_stall <= ($urandom_range(99) < busy_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (busy && idle_cycles > WATCHDOG) begin
        $display("timeout");
        $display("tb_ray_box_slab_test NOT OK");
        $finish;
      end
    end
  end

  task automatic write_reg(rbst_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    ray_reg[idx] = sx(val);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    while (box_q.size() > 0 || in_valid || span_q.size() > 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'(int'($urandom_range(40 << FRAC)) - (20 << FRAC));
    endcase
  endfunction

  function automatic box_t rnd_box();
    box_t b;
    logic [31:0] a, c;
    b = '0;
    for (int k = 0; k < 3; k++) begin
      a = rnd_coord();
      c = rnd_coord();
      if ($urandom_range(9) != 0 && signed'(a) > signed'(c)) {a, c} = {c, a};
      case (k)
        0: {b.min_x, b.max_x} = {a, c};
        1: {b.min_y, b.max_y} = {a, c};
        default: {b.min_z, b.max_z} = {a, c};
      endcase
    end
    return b;
  endfunction

  task automatic load_ray(bit extreme);
    for (int r = 0; r < 8; r++) begin
      logic [31:0] v;
      case ($urandom_range(4))
        0: v = 32'h0;
        1: v = extreme ? ($urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000) : $urandom();
        default: v = 32'(int'($urandom_range(8 << FRAC)) - (4 << FRAC));
      endcase
      if (r == REG_T_START && $urandom_range(1)) v = 32'h80000000;
      if (r == REG_T_END && $urandom_range(1)) v = 32'h7FFFFFFF;
      write_reg(rbst_reg_t'(r), v);
    end
  endtask

  initial begin
    ray_reg = '{0, 0, 0, 65536, 0, 0, 0, 2147483647};
    repeat (7) @(posedge clk);
    rst_n <= 1;
    busy = 1;
    // directed boxes under the reset ray
    box_q.push_back('{32'h0, 32'h00020000, 32'h0, 32'h0, 32'h0, 32'h0});
    box_q.push_back('{32'h00010000, 32'h00020000, 32'hFFFF0000, 32'h00010000,
                      32'hFFFF0000, 32'h00010000});
    box_q.push_back('{32'h0, 32'h00010000, 32'h00010000, 32'h00020000, 32'h0, 32'h0});
    box_q.push_back('{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                      32'h80000000, 32'h7FFFFFFF});
    box_q.push_back('{32'h00020000, 32'h00010000, 32'h0, 32'h0, 32'h0, 32'h0});
    box_q.push_back('{32'h0, 32'h00010000, 32'h00010000, 32'hFFFF0000, 32'h0, 32'h0});
    box_q.push_back('{32'hFFFE0000, 32'hFFFF0000, 32'h0, 32'h0, 32'h0, 32'h0});
    box_q.push_back('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 32'h0});
    drain();
    // tiny direction forces saturation; an empty interval (t_start equal to t_end) always misses
    write_reg(REG_DIR_X, 32'h00000001);
    write_reg(REG_DIR_Y, 32'hFFFFFFFF);
    write_reg(REG_DIR_Z, 32'h80000000);
    write_reg(REG_ORIGIN_X, 32'h80000000);
    write_reg(REG_ORIGIN_Y, 32'h7FFFFFFF);
    write_reg(REG_ORIGIN_Z, 32'h00010000);
    write_reg(REG_T_START, 32'h80000000);
    write_reg(REG_T_END, 32'h7FFFFFFF);
    for (int i = 0; i < 8; i++) box_q.push_back(i < 2 ? box_t'({6{32'h7FFFFFFF}}) : rnd_box());
    drain();
    write_reg(REG_T_START, 32'h00050000);
    write_reg(REG_T_END, 32'h00050000);
    for (int i = 0; i < 4; i++) box_q.push_back(rnd_box());
    drain();
    for (int ph = 0; ph < 12; ph++) begin
      load_ray(ph % 3 == 0);
      busy_pct = (ph == 4) ? 0 : 28;
      if (ph == 6) hold_off = 300;
      for (int i = 0; i < 100; i++) box_q.push_back(rnd_box());
      drain();
    end
    $display("covered %0d boxes (%0d hits) over 15 ray settings, %0d result words",
             n_boxes, n_hits, n_spans);
    if (errors == 0) $display("tb_ray_box_slab_test OK");
    else $display("tb_ray_box_slab_test NOT OK");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rbst_pkg.sv
rtl/rbst_front.sv
rtl/rbst_fifo.sv
rtl/rbst_div.sv
rtl/rbst_back.sv
rtl/ray_box_slab_test.sv
rtl/rbst_chk.sv
tb/tb_ray_box_slab_test.sv
